>>> hdl/trme_pkg.sv
package trme_pkg;

    localparam int MEM_WORDS     = 1024;
    localparam int PROGRAM_WORDS = 1024;
    localparam int MEM_AW        = $clog2(MEM_WORDS);
    localparam int PC_W          = 10;
    localparam int PLEN_W        = 11;
    localparam int REGS          = 32;
    localparam int REG_AW        = 5;
    localparam int XLEN          = 64;
    localparam int IMM_W         = 32;
    localparam int FUNC_W        = 4;

    localparam logic [FUNC_W-1:0] FN_ADDI = 4'd0;
    localparam logic [FUNC_W-1:0] FN_ADD  = 4'd1;
    localparam logic [FUNC_W-1:0] FN_LDI  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_SD   = 4'd3;
    localparam logic [FUNC_W-1:0] FN_LD   = 4'd4;
    localparam logic [FUNC_W-1:0] FN_JAL  = 4'd5;
    localparam logic [FUNC_W-1:0] FN_JALR = 4'd6;
    localparam logic [FUNC_W-1:0] FN_BEQ  = 4'd7;
    localparam logic [FUNC_W-1:0] FN_BNE  = 4'd8;
    localparam logic [FUNC_W-1:0] FN_BLT  = 4'd9;

    localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
    localparam logic [REG_AW-1:0] REG_LINK = 5'd1;

    typedef logic [XLEN-1:0] t_word;

endpackage

>>> hdl/toy_register_machine_executor.sv
// channel   valid          ready          payload
// input     i_in_valid     o_in_ready     i_func i_dest_reg i_src_a i_src_b i_imm i_target
// result    o_out_valid    i_out_ready    o_next_pc o_reg_written o_written_reg
//                                         o_written_value o_done_res
// config    i_cfg_valid    o_cfg_ready    i_cfg_data (program_length)
//
// two stages: register file read at accept, execute with forwarding, result stage.
// one instruction per cycle while results are taken, each held in execute then result.
// ld reads data memory at the end of execute, its data comes out of the result stage.
// after reset the data memory is cleared, all 1024 words, one word a cycle; no input
// transaction is taken meanwhile, config writes are.
// a stalled result holds the result stage; execute keeps one more instruction.
module toy_register_machine_executor
    import trme_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic [REG_AW-1:0]         i_dest_reg,
    input  logic [REG_AW-1:0]         i_src_a,
    input  logic [REG_AW-1:0]         i_src_b,
    input  logic signed [IMM_W-1:0]   i_imm,
    input  logic [PC_W-1:0]           i_target,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [PC_W-1:0]           o_next_pc,
    output logic                      o_reg_written,
    output logic [REG_AW-1:0]         o_written_reg,
    output logic signed [XLEN-1:0]    o_written_value,
    output logic                      o_done_res,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [PLEN_W-1:0]         i_cfg_data
);

    // storage
    t_word              r_rf [REGS];
    logic [REGS-1:0]    r_rf_vld;
    t_word              r_dm [MEM_WORDS];

    logic [PLEN_W-1:0]  r_plen;
    logic [PC_W-1:0]    r_pc;
    logic               r_clr_busy;
    logic [MEM_AW-1:0]  r_clr_addr;

    // execute stage
    logic               r_s1_v;
    logic [FUNC_W-1:0]  r_s1_func;
    logic [REG_AW-1:0]  r_s1_rd;
    logic [REG_AW-1:0]  r_s1_ra;
    logic [REG_AW-1:0]  r_s1_rb;
    logic [IMM_W-1:0]   r_s1_imm;
    logic [PC_W-1:0]    r_s1_tgt;
    t_word              r_rd_a;
    t_word              r_rd_b;
    logic               r_ok_a;
    logic               r_ok_b;

    // result stage
    logic               r_s2_v;
    logic               r_s2_ld;
    logic               r_s2_wr;
    logic [REG_AW-1:0]  r_s2_rd;
    t_word              r_s2_val;
    logic [PC_W-1:0]    r_s2_pc;
    logic               r_s2_done;
    t_word              r_mem_q;

    // last committed write, covers a commit on the same edge as the read
    logic               r_lc_v;
    logic [REG_AW-1:0]  r_lc_rd;
    t_word              r_lc_val;
    t_word              r_x1;

    logic               in_fire, out_fire, s2_free, s1_go, commit;
    t_word              s2_wval, op_a, op_b, x1_val, imm_ext, op2, sum;
    logic [PC_W:0]      pc_inc;
    logic [PC_W-1:0]    n_pc;
    logic               n_wr, take;
    t_word              n_val;
    logic               n_done;

    function automatic t_word fwd(
        input logic [REG_AW-1:0] idx,
        input t_word             mdata,
        input logic              ok,
        input logic              s2_hit_en,
        input logic [REG_AW-1:0] s2_rd,
        input t_word             s2_val,
        input logic              lc_v,
        input logic [REG_AW-1:0] lc_rd,
        input t_word             lc_val
    );
        t_word v;
        if (idx == REG_ZERO) v = '0;
        else if (s2_hit_en && s2_rd == idx) v = s2_val;
        else if (lc_v && lc_rd == idx) v = lc_val;
        else if (ok) v = mdata;
        else v = '0;
        return v;
    endfunction

    assign s2_free    = !r_s2_v || i_out_ready;
    assign s1_go      = r_s1_v && s2_free;
    assign o_in_ready = !r_clr_busy && (!r_s1_v || s2_free);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_s2_v && i_out_ready;
    assign commit     = out_fire && r_s2_wr;
    assign o_cfg_ready = 1'b1;

    assign s2_wval = r_s2_ld ? r_mem_q : r_s2_val;

    always_comb begin
        op_a = fwd(r_s1_ra, r_rd_a, r_ok_a, r_s2_v && r_s2_wr, r_s2_rd, s2_wval,
                   r_lc_v, r_lc_rd, r_lc_val);
        op_b = fwd(r_s1_rb, r_rd_b, r_ok_b, r_s2_v && r_s2_wr, r_s2_rd, s2_wval,
                   r_lc_v, r_lc_rd, r_lc_val);
        // jalr clears rd before reading x1
        if (r_s1_rd == REG_LINK) x1_val = '0;
        else if (r_s2_v && r_s2_wr && r_s2_rd == REG_LINK) x1_val = s2_wval;
        else x1_val = r_x1;

        imm_ext = {{(XLEN-IMM_W){r_s1_imm[IMM_W-1]}}, r_s1_imm};
        op2     = (r_s1_func == FN_ADD) ? op_b : imm_ext;
        sum     = op_a + op2;
        pc_inc  = {1'b0, r_pc} + 1'b1;
        n_pc    = pc_inc[PC_W-1:0];
        n_wr    = 1'b0;
        n_val   = '0;
        case (r_s1_func)
            FN_ADDI, FN_ADD: begin
                n_wr  = 1'b1;
                n_val = sum;
            end
            FN_LDI: begin
                n_wr  = 1'b1;
                n_val = imm_ext;
            end
            FN_LD: n_wr = 1'b1;
            FN_JAL: begin
                n_wr  = 1'b1;
                n_val = {{(XLEN-PC_W-1){1'b0}}, pc_inc};
                n_pc  = r_s1_tgt;
            end
            FN_JALR: begin
                n_wr = 1'b1;
                n_pc = x1_val[PC_W-1:0];
            end
            FN_BEQ: if (op_a == op_b) n_pc = r_s1_tgt;
            FN_BNE: if (op_a != imm_ext) n_pc = r_s1_tgt;
            FN_BLT: if ($signed(op_a) < $signed(op_b)) n_pc = r_s1_tgt;
            default: ;
        endcase
        take   = n_wr && (r_s1_rd != REG_ZERO);
        n_done = {1'b0, n_pc} >= r_plen;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen     <= '0;
            r_pc       <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_lc_v     <= 1'b0;
            r_rf_vld   <= '0;
            r_x1       <= '0;
        end else begin
            if (i_cfg_valid) r_plen <= i_cfg_data;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == MEM_AW'(MEM_WORDS - 1)) r_clr_busy <= 1'b0;
            end
            if (in_fire) r_s1_v <= 1'b1;
            else if (s1_go) r_s1_v <= 1'b0;
            if (s1_go) begin
                r_s2_v <= 1'b1;
                r_pc   <= n_pc;
            end else if (out_fire) begin
                r_s2_v <= 1'b0;
            end
            if (commit) begin
                r_lc_v             <= 1'b1;
                r_rf_vld[r_s2_rd]  <= 1'b1;
                if (r_s2_rd == REG_LINK) r_x1 <= s2_wval;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_func <= i_func;
            r_s1_rd   <= i_dest_reg;
            r_s1_ra   <= i_src_a;
            r_s1_rb   <= i_src_b;
            r_s1_imm  <= i_imm;
            r_s1_tgt  <= i_target;
            r_ok_a    <= r_rf_vld[i_src_a];
            r_ok_b    <= r_rf_vld[i_src_b];
        end
        if (s1_go) begin
            r_s2_ld   <= take && (r_s1_func == FN_LD);
            r_s2_wr   <= take;
            r_s2_rd   <= take ? r_s1_rd : REG_ZERO;
            r_s2_val  <= take ? n_val : '0;
            r_s2_pc   <= n_pc;
            r_s2_done <= n_done;
        end
        if (commit) begin
            r_lc_rd  <= r_s2_rd;
            r_lc_val <= s2_wval;
        end
    end

    // register file, one write and two reads
    always_ff @(posedge i_clk) begin
        if (commit) r_rf[r_s2_rd] <= s2_wval;
        if (in_fire) begin
            r_rd_a <= r_rf[i_src_a];
            r_rd_b <= r_rf[i_src_b];
        end
    end

    // data memory, clear sweep shares the write port with sd
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) r_dm[r_clr_addr] <= '0;
        else if (s1_go && r_s1_func == FN_SD) r_dm[sum[MEM_AW-1:0]] <= op_b;
        if (s1_go && r_s1_func == FN_LD) r_mem_q <= r_dm[op_a[MEM_AW-1:0]];
    end

    assign o_out_valid     = r_s2_v;
    assign o_next_pc       = r_s2_pc;
    assign o_reg_written   = r_s2_wr;
    assign o_written_reg   = r_s2_rd;
    assign o_written_value = r_s2_wr ? s2_wval : '0;
    assign o_done_res      = r_s2_done;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_in_ready)
        else $error("input taken during memory clear");

    a_no_x0_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (r_s2_rd != REG_ZERO))
        else $error("commit to x0");

    a_quiet_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_reg_written) |-> (o_written_reg == REG_ZERO
            && o_written_value == '0))
        else $error("write fields set without a register write");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_v)
        else $error("accepted instruction lost");

    a_pc_moves_with_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!s1_go && !$past(r_clr_busy)) |=> $stable(r_pc))
        else $error("pc changed without an executed instruction");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import trme_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 300;

    localparam logic [FUNC_W-1:0] FN_UNDEF_LO = 4'd10;
    localparam logic [FUNC_W-1:0] FN_UNDEF_HI = 4'd15;
    localparam logic [PLEN_W-1:0] PLEN_MAX    = 11'd1024;

    typedef struct {
        logic [FUNC_W-1:0]       func;
        logic [REG_AW-1:0]       rd;
        logic [REG_AW-1:0]       rs_a;
        logic [REG_AW-1:0]       rs_b;
        logic signed [IMM_W-1:0] imm;
        logic [PC_W-1:0]         target;
    } t_instr;

    typedef struct {
        logic [PC_W-1:0]   next_pc;
        logic              reg_written;
        logic [REG_AW-1:0] written_reg;
        t_word             written_value;
        logic              done;
    } t_exec_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [FUNC_W-1:0]       i_func = '0;
    logic [REG_AW-1:0]       i_dest_reg = '0;
    logic [REG_AW-1:0]       i_src_a = '0;
    logic [REG_AW-1:0]       i_src_b = '0;
    logic signed [IMM_W-1:0] i_imm = '0;
    logic [PC_W-1:0]         i_target = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b1;
    logic [PC_W-1:0]         o_next_pc;
    logic                    o_reg_written;
    logic [REG_AW-1:0]       o_written_reg;
    logic signed [XLEN-1:0]  o_written_value;
    logic                    o_done_res;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [PLEN_W-1:0]       i_cfg_data = '0;

    // machine state as the block should hold it
    t_word           arch_regs [REGS];
    t_word           data_mem [MEM_WORDS];
    logic [PC_W-1:0] arch_pc;
    logic [PLEN_W-1:0] prog_len;

    t_instr       pending_instrs [$];
    t_exec_result expected_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_left      = 0;
    bit in_taken       = 1'b0;
    int stuck_cycles   = 0;
    int mismatches     = 0;
    int instrs_taken   = 0;
    int results_seen   = 0;
    int cfg_writes     = 0;
    int op_seen [16];

    toy_register_machine_executor u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_dest_reg      (i_dest_reg),
        .i_src_a         (i_src_a),
        .i_src_b         (i_src_b),
        .i_imm           (i_imm),
        .i_target        (i_target),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_next_pc       (o_next_pc),
        .o_reg_written   (o_reg_written),
        .o_written_reg   (o_written_reg),
        .o_written_value (o_written_value),
        .o_done_res      (o_done_res),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_exec_result execute_instr(t_instr ins);
        t_word           a;
        t_word           b;
        t_word           imm64;
        t_word           wval;
        t_word           addr;
        logic [PC_W-1:0] nxt;
        logic            wr;
        t_exec_result    res;
        a     = arch_regs[ins.rs_a];
        b     = arch_regs[ins.rs_b];
        imm64 = {{(XLEN-IMM_W){ins.imm[IMM_W-1]}}, ins.imm};
        nxt   = arch_pc + 1'b1;
        wr    = 1'b0;
        wval  = '0;
        case (ins.func)
            FN_ADDI: begin
                wr   = 1'b1;
                wval = a + imm64;
            end
            FN_ADD: begin
                wr   = 1'b1;
                wval = a + b;
            end
            FN_LDI: begin
                wr   = 1'b1;
                wval = imm64;
            end
            FN_SD: begin
                addr = a + imm64;
                data_mem[addr[MEM_AW-1:0]] = b;
            end
            FN_LD: begin
                wr   = 1'b1;
                wval = data_mem[a[MEM_AW-1:0]];
            end
            FN_JAL: begin
                // link is the full pc + 1, not wrapped
                wr   = 1'b1;
                wval = t_word'(arch_pc) + 1;
                nxt  = ins.target;
            end
            FN_JALR: begin
                // rd is cleared before x1 is read
                wr = 1'b1;
                if (ins.rd != REG_ZERO) begin
                    arch_regs[ins.rd] = '0;
                end
                nxt = arch_regs[REG_LINK][PC_W-1:0];
            end
            FN_BEQ: begin
                if (a == b) nxt = ins.target;
            end
            FN_BNE: begin
                if (a != imm64) nxt = ins.target;
            end
            FN_BLT: begin
                if ($signed(a) < $signed(b)) nxt = ins.target;
            end
            default: ;
        endcase
        if (wr && ins.rd != REG_ZERO) begin
            arch_regs[ins.rd] = wval;
        end else begin
            wr   = 1'b0;
            wval = '0;
        end
        arch_pc           = nxt;
        res.next_pc       = nxt;
        res.reg_written   = wr;
        res.written_reg   = wr ? ins.rd : REG_ZERO;
        res.written_value = wval;
        res.done          = ({1'b0, nxt} >= prog_len);
        return res;
    endfunction

    function automatic void queue_instr(input int func, input int rd,
                                        input int rs_a, input int rs_b,
                                        input logic [IMM_W-1:0] imm,
                                        input logic [PC_W-1:0] target);
        t_instr ins;
        ins.func   = FUNC_W'(func);
        ins.rd     = REG_AW'(rd);
        ins.rs_a   = REG_AW'(rs_a);
        ins.rs_b   = REG_AW'(rs_b);
        ins.imm    = imm;
        ins.target = target;
        pending_instrs = {pending_instrs, ins};
    endfunction

    function automatic int rand_reg();
        return $urandom_range(0, REGS - 1);
    endfunction

    function automatic logic [PC_W-1:0] rand_target();
        return PC_W'($urandom_range(0, PROGRAM_WORDS - 1));
    endfunction

    function automatic logic [IMM_W-1:0] rand_imm();
        if ($urandom_range(0, 1) == 0) return $urandom();
        return $urandom_range(0, 2047) - 1024;
    endfunction

    task automatic queue_random_program(input int count);
        int made;
        int pick;
        int ra;
        int rb;
        int rc;
        int addr;
        int off;
        int n;
        logic [IMM_W-1:0] v;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            ra   = $urandom_range(1, REGS - 1);
            rb   = rand_reg();
            rc   = $urandom_range(1, REGS - 1);
            if (pick < 12) begin
                // store a word, then load it back through an aliased address
                addr = $urandom_range(0, MEM_WORDS - 1);
                off  = $urandom_range(0, 4095) - 2048;
                queue_instr(FN_LDI, ra, rand_reg(), rand_reg(), addr, rand_target());
                queue_instr(FN_SD, rand_reg(), ra, rb, off, rand_target());
                queue_instr(FN_LDI, rc, rand_reg(), rand_reg(),
                            addr + off + MEM_WORDS * $urandom_range(0, 4000), rand_target());
                queue_instr(FN_LD, rand_reg(), rc, rand_reg(), $urandom(), rand_target());
                made += 4;
            end else if (pick < 20) begin
                // repeated doubling pushes values through 64-bit wrap
                n = $urandom_range(3, 40);
                queue_instr(FN_LDI, ra, rand_reg(), rand_reg(), $urandom(), rand_target());
                repeat (n) begin
                    queue_instr(FN_ADD, ra, ra, ra, rand_imm(), rand_target());
                end
                made += n + 1;
            end else if (pick < 28) begin
                // call and return through the link register
                queue_instr(FN_JAL, REG_LINK, rand_reg(), rand_reg(), rand_imm(), rand_target());
                queue_instr($urandom_range(FN_ADDI, FN_BLT), rand_reg(), rand_reg(), rand_reg(),
                            rand_imm(), rand_target());
                queue_instr(FN_JALR, rand_reg(), rand_reg(), rand_reg(), rand_imm(),
                            rand_target());
                made += 3;
            end else if (pick < 36) begin
                // branches whose operands are equal
                v = rand_imm();
                queue_instr(FN_BEQ, rand_reg(), rb, rb, rand_imm(), rand_target());
                queue_instr(FN_LDI, ra, rand_reg(), rand_reg(), v, rand_target());
                queue_instr(FN_BNE, rand_reg(), ra, rand_reg(), v, rand_target());
                made += 3;
            end else if (pick < 42) begin
                queue_instr($urandom_range(FN_UNDEF_LO, FN_UNDEF_HI), rand_reg(), rand_reg(),
                            rand_reg(), $urandom(), rand_target());
                made++;
            end else begin
                queue_instr($urandom_range(FN_ADDI, FN_BLT), rand_reg(), rand_reg(), rand_reg(),
                            rand_imm(), rand_target());
                made++;
            end
        end
    endtask

    task automatic wait_quiet();
        while (pending_instrs.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_prog_len(input logic [PLEN_W-1:0] len);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do begin
            @(posedge i_clk);
        end while (!(i_cfg_valid && o_cfg_ready));
        prog_len = len;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [PLEN_W-1:0] len, input int idle_pct,
                             input int stall_pct, input bit squeeze);
        wait_quiet();
        write_prog_len(len);
        @(posedge i_clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        queue_random_program(PHASE_ITEMS);
        if (squeeze) hold_req = HOLD_CYCLES;
        wait_quiet();
    endtask

    // instruction driver
    always @(negedge i_clk) begin : drive_instr
        t_instr ins;
        if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                ins = pending_instrs.pop_front();
                i_in_valid <= 1'b1;
                i_func     <= ins.func;
                i_dest_reg <= ins.rd;
                i_src_a    <= ins.rs_a;
                i_src_b    <= ins.rs_b;
                i_imm      <= ins.imm;
                i_target   <= ins.target;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with an occasional long hold-off
    always @(negedge i_clk) begin : drive_ready
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_instr       ins;
        t_exec_result want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                ins.func   = i_func;
                ins.rd     = i_dest_reg;
                ins.rs_a   = i_src_a;
                ins.rs_b   = i_src_b;
                ins.imm    = i_imm;
                ins.target = i_target;
                want = execute_instr(ins);
                expected_results = {expected_results, want};
                op_seen[i_func]++;
                instrs_taken++;
                in_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result: pc %0d wr %0b reg %0d value %h done %0b",
                                 o_next_pc, o_reg_written, o_written_reg, o_written_value,
                                 o_done_res);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (want.next_pc !== o_next_pc || want.reg_written !== o_reg_written ||
                        want.written_reg !== o_written_reg ||
                        want.written_value !== o_written_value || want.done !== o_done_res) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch at result %0d:", results_seen);
                            $display("  expected pc %0d wr %0b reg %0d value %h done %0b",
                                     want.next_pc, want.reg_written, want.written_reg,
                                     want.written_value, want.done);
                            $display("  actual   pc %0d wr %0b reg %0d value %h done %0b",
                                     o_next_pc, o_reg_written, o_written_reg, o_written_value,
                                     o_done_res);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : stimulus
        int undef_ops;
        for (int i = 0; i < REGS; i++) arch_regs[i] = '0;
        for (int i = 0; i < MEM_WORDS; i++) data_mem[i] = '0;
        for (int i = 0; i < 16; i++) op_seen[i] = 0;
        arch_pc  = '0;
        prog_len = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed program, run under the reset program length
        queue_instr(FN_LDI, 1, 0, 0, 32'h7fff_ffff, '0);
        queue_instr(FN_LDI, 2, 31, 31, 32'h8000_0000, 10'h3ff);
        queue_instr(FN_ADDI, 3, 1, 0, 32'hffff_ffff, '0);
        queue_instr(FN_ADD, 4, 1, 2, '0, '0);
        queue_instr(FN_ADDI, 4, 4, 0, 32'h8000_0000, '0);
        queue_instr(FN_SD, 0, 0, 4, 32'd1023, '0);
        // a negative base of -2^31 plus 5 lands on word 5 once the address is cut to its low 10 bits
        queue_instr(FN_SD, 0, 2, 1, 32'd5, '0);
        queue_instr(FN_LDI, 6, 0, 0, 32'd8191, '0);
        queue_instr(FN_LD, 7, 6, 0, '0, '0);
        queue_instr(FN_LDI, 9, 0, 0, 32'd5, '0);
        queue_instr(FN_LD, 31, 9, 0, '0, '0);
        queue_instr(FN_LD, 8, 0, 0, '0, '0);
        queue_instr(FN_ADD, REG_ZERO, 1, 1, '0, '0);
        queue_instr(FN_JAL, REG_LINK, 0, 0, '0, 10'h3ff);
        // link from the last pc is 1024, next pc is the target 1023 again
        queue_instr(FN_JAL, 31, 0, 0, '0, 10'h3ff);
        queue_instr(FN_BEQ, 0, 0, 0, '0, 10'd100);
        queue_instr(FN_BEQ, 0, 1, 2, '0, 10'd200);
        queue_instr(FN_BNE, 0, 31, 0, 32'd1024, 10'd300);
        queue_instr(FN_BNE, 0, 2, 0, '0, 10'h2aa);
        queue_instr(FN_BLT, 0, 2, 1, '0, 10'h155);
        queue_instr(FN_BLT, 0, 1, 2, '0, 10'h0f0);
        queue_instr(FN_JALR, 5, 0, 0, '0, '0);
        queue_instr(FN_JALR, REG_ZERO, 0, 0, '0, '0);
        queue_instr(FN_JALR, REG_LINK, 0, 0, '0, '0);
        queue_instr(FN_UNDEF_LO, 3, 1, 2, 32'hffff_ffff, 10'h3ff);
        queue_instr(FN_UNDEF_HI, 31, 31, 31, 32'h8000_0000, '0);
        wait_quiet();

        run_phase(PLEN_MAX, 0, 0, 1'b0);
        run_phase(11'd1, 63, 0, 1'b0);
        run_phase(11'd0, 0, 63, 1'b0);
        run_phase(PLEN_W'($urandom_range(0, PLEN_MAX)), 27, 27, 1'b0);
        run_phase(PLEN_MAX - 1'b1, 0, 0, 1'b1);
        run_phase(PLEN_W'($urandom_range(0, PLEN_MAX)), 27, 27, 1'b0);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        undef_ops = 0;
        for (int i = FN_UNDEF_LO; i <= FN_UNDEF_HI; i++) undef_ops += op_seen[i];
        $display("ran %0d instructions under %0d program lengths: %0d sd, %0d ld, %0d jal,",
                 instrs_taken, cfg_writes + 1, op_seen[FN_SD], op_seen[FN_LD], op_seen[FN_JAL]);
        $display("%0d jalr, %0d branches, %0d undefined; %0d results checked, %0d bad",
                 op_seen[FN_JALR], op_seen[FN_BEQ] + op_seen[FN_BNE] + op_seen[FN_BLT],
                 undef_ops, results_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
